>>> hdl/widget_message_deframer_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef WIDGET_MESSAGE_DEFRAMER_MACROS_SVH
`define WIDGET_MESSAGE_DEFRAMER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define WMD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");
// Next-cycle implication, checked out of reset.
`define WMD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");
`else
`define WMD_ASSERT_IMP(lbl, ante, cons)
`define WMD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> hdl/wmd_pkg.sv
// Types and constants for the widget message deframer.
`default_nettype none

package wmd_pkg;

    localparam int BYTE_W = 8;
    localparam int IDX_W  = 10;
    localparam int LEN_FULL_W = 16;

    // Parameter defaults
    localparam int MAX_PAYLOAD_DEF   = 600;
    localparam int SCAN_LIMIT_DEF    = 512;
    localparam int ATTEMPT_LIMIT_DEF = 100;

    // Framing codes
    localparam logic [BYTE_W-1:0] START_CODE = 8'h7E;
    localparam logic [BYTE_W-1:0] END_CODE   = 8'hE7;

    // Configuration registers
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WANTED_LABEL = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COPY_LIMIT   = 1'b1;
    localparam logic [BYTE_W-1:0] WANTED_LABEL_RST = 8'h00;
    localparam logic [IDX_W-1:0]  COPY_LIMIT_RST   = 10'd600;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TIMEOUT   = 3'd1,
        ST_NO_START  = 3'd2,
        ST_LABEL     = 3'd3,
        ST_TOO_LONG  = 3'd4,
        ST_BAD_END   = 3'd5
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              timed_out;
    } in_beat_t;

    typedef struct packed {
        logic              out_kind;
        logic [BYTE_W-1:0] out_byte;
        logic [IDX_W-1:0]  out_index;
        status_t           status;
        logic [IDX_W-1:0]  copied_count;
        logic              last;
    } out_beat_t;

endpackage

`default_nettype wire

>>> hdl/wmd_frame.sv
// Frame parser: per-byte state update and result generation.
`default_nettype none

module wmd_frame #(
    parameter int MAX_PAYLOAD   = wmd_pkg::MAX_PAYLOAD_DEF,
    parameter int SCAN_LIMIT    = wmd_pkg::SCAN_LIMIT_DEF,
    parameter int ATTEMPT_LIMIT = wmd_pkg::ATTEMPT_LIMIT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire wmd_pkg::in_beat_t             in_data,
    input  wire logic [wmd_pkg::BYTE_W-1:0]    wanted_label,
    input  wire logic [wmd_pkg::IDX_W-1:0]     copy_limit,
    output logic                               res_valid,
    output wmd_pkg::out_beat_t                 res_data
);

    localparam int SCAN_W = $clog2(SCAN_LIMIT + 1);
    localparam int ATT_W  = $clog2(ATTEMPT_LIMIT + 1);
    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W  = wmd_pkg::IDX_W;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LABEL,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_END
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [SCAN_W-1:0]         scan_reg, scan_next;
    logic [ATT_W-1:0]          attempt_reg, attempt_next;
    logic [wmd_pkg::BYTE_W-1:0] len_low_reg, len_low_next;
    logic [LEN_W-1:0]          frame_len_reg, frame_len_next;
    logic [IDX_W-1:0]          pay_idx_reg, pay_idx_next;

    logic                      do_report;
    wmd_pkg::status_t          rep_status;
    logic [IDX_W-1:0]          rep_copied;
    logic                      emit_byte;

    logic [SCAN_W-1:0]         scan_inc;
    logic [ATT_W-1:0]          attempt_inc;
    logic [IDX_W-1:0]          pay_idx_inc;
    logic [wmd_pkg::LEN_FULL_W-1:0] len_full;
    logic [IDX_W-1:0]          frame_len_ext;

    assign scan_inc      = scan_reg + SCAN_W'(1);
    assign attempt_inc   = attempt_reg + ATT_W'(1);
    assign pay_idx_inc   = pay_idx_reg + IDX_W'(1);
    assign len_full      = {in_data.rx_byte, len_low_reg};
    assign frame_len_ext = IDX_W'(frame_len_reg);

    // Decide the next state and any result for the byte at the input
    always_comb
    begin
        phase_next     = phase_reg;
        scan_next      = scan_reg;
        attempt_next   = attempt_reg;
        len_low_next   = len_low_reg;
        frame_len_next = frame_len_reg;
        pay_idx_next   = pay_idx_reg;
        do_report      = 1'b0;
        rep_status     = wmd_pkg::ST_OK;
        rep_copied     = '0;
        emit_byte      = 1'b0;

        if (in_data.timed_out)
        begin
            do_report  = 1'b1;
            rep_status = wmd_pkg::ST_TIMEOUT;
        end
        else
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (in_data.rx_byte == wmd_pkg::START_CODE)
                    begin
                        scan_next  = '0;
                        phase_next = PH_LABEL;
                    end
                    else if (scan_inc >= SCAN_W'(SCAN_LIMIT))
                    begin
                        do_report  = 1'b1;
                        rep_status = wmd_pkg::ST_NO_START;
                    end
                    else
                    begin
                        scan_next = scan_inc;
                    end
                end
                PH_LABEL:
                begin
                    if (in_data.rx_byte == wanted_label)
                    begin
                        phase_next = PH_LEN_LO;
                    end
                    else if (attempt_inc >= ATT_W'(ATTEMPT_LIMIT))
                    begin
                        do_report  = 1'b1;
                        rep_status = wmd_pkg::ST_LABEL;
                    end
                    else
                    begin
                        attempt_next = attempt_inc;
                        scan_next    = '0;
                        phase_next   = PH_HUNT;
                    end
                end
                PH_LEN_LO:
                begin
                    len_low_next = in_data.rx_byte;
                    phase_next   = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    if (len_full > wmd_pkg::LEN_FULL_W'(MAX_PAYLOAD))
                    begin
                        do_report  = 1'b1;
                        rep_status = wmd_pkg::ST_TOO_LONG;
                    end
                    else
                    begin
                        frame_len_next = len_full[LEN_W-1:0];
                        pay_idx_next   = '0;
                        phase_next     = (len_full == '0) ? PH_END : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    emit_byte    = (pay_idx_reg < copy_limit);
                    pay_idx_next = pay_idx_inc;
                    if (pay_idx_inc >= frame_len_ext)
                    begin
                        phase_next = PH_END;
                    end
                end
                PH_END:
                begin
                    do_report = 1'b1;
                    if (in_data.rx_byte == wmd_pkg::END_CODE)
                    begin
                        rep_status = wmd_pkg::ST_OK;
                        rep_copied = (frame_len_ext < copy_limit) ? frame_len_ext
                                                                  : copy_limit;
                    end
                    else
                    begin
                        rep_status = wmd_pkg::ST_BAD_END;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        // Every report drops the frame and restarts the hunt
        if (do_report)
        begin
            phase_next     = PH_HUNT;
            scan_next      = '0;
            attempt_next   = '0;
            len_low_next   = '0;
            frame_len_next = '0;
            pay_idx_next   = '0;
        end
    end

    // Build the result beat
    always_comb
    begin
        res_valid                 = accept && (do_report || emit_byte);
        res_data.out_kind         = do_report ? wmd_pkg::KIND_REPORT : wmd_pkg::KIND_PAYLOAD;
        res_data.out_byte         = do_report ? '0 : in_data.rx_byte;
        res_data.out_index        = do_report ? '0 : pay_idx_reg;
        res_data.status           = rep_status;
        res_data.copied_count     = rep_copied;
        res_data.last             = do_report;
    end

    // Hold frame state; advance on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            scan_reg      <= '0;
            attempt_reg   <= '0;
            len_low_reg   <= '0;
            frame_len_reg <= '0;
            pay_idx_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            scan_reg      <= scan_next;
            attempt_reg   <= attempt_next;
            len_low_reg   <= len_low_next;
            frame_len_reg <= frame_len_next;
            pay_idx_reg   <= pay_idx_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/wmd_out_buf.sv
// Two-entry result buffer: output register plus skid register.
`default_nettype none

module wmd_out_buf (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               res_valid,
    input  wire wmd_pkg::out_beat_t res_data,
    output logic                    full,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output wmd_pkg::out_beat_t      out_data
);

    logic               out_valid_reg;
    wmd_pkg::out_beat_t out_data_reg;
    logic               skid_valid_reg;
    wmd_pkg::out_beat_t skid_data_reg;
    logic               out_take;

    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign full      = skid_valid_reg;

    // Control: new results fill the output register first, else the skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (res_valid)
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: load output from skid or from the parser
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_data_reg <= res_data;
            end
            else
            begin
                skid_data_reg <= res_data;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/widget_message_deframer.sv
// Widget message deframer: one received byte or timeout mark per beat in, at
// most one result beat out per input beat. A beat is taken every cycle while
// in_stall is low: each byte updates the frame state, and results pass through
// a two-entry output buffer, so in_stall rises only once the output and skid
// registers both hold results that the consumer has not taken. Payload bytes up
// to the copy limit come out as they arrive, followed by one report (last = 1)
// carrying the status and, for a good frame, the count of bytes passed; on any
// error status the consumer drops the bytes already delivered for that frame.
// Register writes (index 0: wanted label, index 1: copy limit) are registered.
`default_nettype none

`include "widget_message_deframer_macros.svh"

module widget_message_deframer #(
    parameter int MAX_PAYLOAD   = wmd_pkg::MAX_PAYLOAD_DEF,
    parameter int SCAN_LIMIT    = wmd_pkg::SCAN_LIMIT_DEF,
    parameter int ATTEMPT_LIMIT = wmd_pkg::ATTEMPT_LIMIT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire wmd_pkg::in_beat_t                 in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output wmd_pkg::out_beat_t                     out_data,
    input  wire logic                              cfg_we,
    input  wire logic [wmd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [wmd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [wmd_pkg::BYTE_W-1:0] wanted_label_reg;
    logic [wmd_pkg::IDX_W-1:0]  copy_limit_reg;
    logic                       in_accept;
    logic                       res_valid;
    wmd_pkg::out_beat_t         res_data;
    logic                       buf_full;

    assign in_stall  = buf_full;
    assign in_accept = in_valid && !buf_full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_label_reg <= wmd_pkg::WANTED_LABEL_RST;
            copy_limit_reg   <= wmd_pkg::COPY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wmd_pkg::CFG_WANTED_LABEL:
                    wanted_label_reg <= cfg_data[wmd_pkg::BYTE_W-1:0];
                wmd_pkg::CFG_COPY_LIMIT:
                    copy_limit_reg <= cfg_data[wmd_pkg::IDX_W-1:0];
                default:
                    copy_limit_reg <= copy_limit_reg;
            endcase
        end
    end

    wmd_frame #(
        .MAX_PAYLOAD   (MAX_PAYLOAD),
        .SCAN_LIMIT    (SCAN_LIMIT),
        .ATTEMPT_LIMIT (ATTEMPT_LIMIT)
    ) u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .in_data      (in_data),
        .wanted_label (wanted_label_reg),
        .copy_limit   (copy_limit_reg),
        .res_valid    (res_valid),
        .res_data     (res_data)
    );

    wmd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_data  (res_data),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // A full skid stage implies a waiting output beat
    `WMD_ASSERT_IMP(a_skid_implies_out, in_stall, out_valid)
    // Back-pressure starts only behind a stalled output beat
    `WMD_ASSERT_NXT(a_stall_cause, !in_stall && !(out_valid && out_stall), !in_stall)
    // Reports and payload beats are told apart consistently
    `WMD_ASSERT_IMP(a_kind_last, out_valid, out_data.last == out_data.out_kind)

endmodule

`default_nettype wire

>>> sim/tb_widget_message_deframer.sv
// Self-checking testbench for the widget message deframer: byte stream in, payload/report beats out.
module tb_widget_message_deframer;
    import wmd_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 60;
    localparam int CYCLE_LIMIT   = 400000;

    // Frame tracking phases of the predictor
    typedef enum logic [2:0] {
        LP_HUNT,
        LP_LABEL,
        LP_LEN_LOW,
        LP_LEN_HIGH,
        LP_PAYLOAD,
        LP_END
    } link_phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_beat_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_beat_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Byte stream waiting to be sent and results the deframer still owes
    in_beat_t rx_stream[$];
    out_beat_t frame_results_due[$];

    // Predictor copy of registers and frame state
    logic [BYTE_W-1:0] label_reg = WANTED_LABEL_RST;
    logic [IDX_W-1:0]  limit_reg = COPY_LIMIT_RST;
    link_phase_t       lp = LP_HUNT;
    logic [9:0]        scan_cnt = '0;
    logic [6:0]        attempt_cnt = '0;
    logic [7:0]        len_low = '0;
    logic [15:0]       frame_len = '0;
    logic [IDX_W-1:0]  pay_idx = '0;

    int beats_queued = 0;
    int beats_taken = 0;
    int payload_checked = 0;
    int report_tally[0:7];
    int mismatches = 0;
    int settings_used = 1;
    int cycle_count = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int stall_left = 0;
    int gap_left = 0;
    bit calm = 1'b0;

    widget_message_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                     frame_results_due.size());
            $display("tb_widget_message_deframer: errors");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at cycle %0d: %s got %0d, want %0d", cycle_count, what, got, want);
    endtask

    // Emit an end-of-frame report and drop back to the hunt
    task automatic close_frame(input status_t st, input logic [IDX_W-1:0] copied);
        out_beat_t r;
        r = '0;
        r.out_kind = KIND_REPORT;
        r.status = st;
        r.copied_count = copied;
        r.last = 1'b1;
        frame_results_due.push_back(r);
        lp = LP_HUNT;
        scan_cnt = '0;
        attempt_cnt = '0;
        len_low = '0;
        frame_len = '0;
        pay_idx = '0;
    endtask

    // Advance the frame state by one received beat
    task automatic track_frame(input in_beat_t beat);
        out_beat_t r;
        if (beat.timed_out)
            close_frame(ST_TIMEOUT, '0);
        else
        begin
            case (lp)
                LP_HUNT:
                begin
                    if (beat.rx_byte == START_CODE)
                    begin
                        scan_cnt = '0;
                        lp = LP_LABEL;
                    end
                    else
                    begin
                        scan_cnt = scan_cnt + 1'b1;
                        if (scan_cnt >= SCAN_LIMIT_DEF)
                            close_frame(ST_NO_START, '0);
                    end
                end
                LP_LABEL:
                begin
                    if (beat.rx_byte == label_reg)
                        lp = LP_LEN_LOW;
                    else
                    begin
                        attempt_cnt = attempt_cnt + 1'b1;
                        if (attempt_cnt >= ATTEMPT_LIMIT_DEF)
                            close_frame(ST_LABEL, '0);
                        else
                        begin
                            scan_cnt = '0;
                            lp = LP_HUNT;
                        end
                    end
                end
                LP_LEN_LOW:
                begin
                    len_low = beat.rx_byte;
                    lp = LP_LEN_HIGH;
                end
                LP_LEN_HIGH:
                begin
                    frame_len = {beat.rx_byte, len_low};
                    if (frame_len > MAX_PAYLOAD_DEF)
                        close_frame(ST_TOO_LONG, '0);
                    else
                    begin
                        pay_idx = '0;
                        lp = (frame_len == 0) ? LP_END : LP_PAYLOAD;
                    end
                end
                LP_PAYLOAD:
                begin
                    if (pay_idx < limit_reg)
                    begin
                        r = '0;
                        r.out_kind = KIND_PAYLOAD;
                        r.out_byte = beat.rx_byte;
                        r.out_index = pay_idx;
                        frame_results_due.push_back(r);
                    end
                    pay_idx = pay_idx + 1'b1;
                    if (pay_idx >= frame_len)
                        lp = LP_END;
                end
                LP_END:
                begin
                    if (beat.rx_byte == END_CODE)
                        close_frame(ST_OK, (frame_len < limit_reg) ? frame_len[IDX_W-1:0]
                                                                   : limit_reg);
                    else
                        close_frame(ST_BAD_END, '0);
                end
                default:
                    lp = LP_HUNT;
            endcase
        end
    endtask

    // Sender: offer queued beats, hold a stalled beat, idle in bursts
    always @(posedge clk)
    begin
        logic took;
        if (rst_n)
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                track_frame(in_data);
                beats_taken++;
            end
            if (in_valid && !took)
                in_valid <= 1'b1;
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (rx_stream.size() != 0)
            begin
                if (!calm && $urandom_range(0, 7) == 0)
                begin
                    gap_left = $urandom_range(1, 7) - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_data <= rx_stream.pop_front();
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: check each beat taken, stall in bursts or for a long hold-off
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (frame_results_due.size() == 0)
                    flag_mismatch("unexpected result, kind", out_data.out_kind, -1);
                else
                begin
                    want = frame_results_due.pop_front();
                    if (out_data.out_kind !== want.out_kind)
                        flag_mismatch("out_kind", out_data.out_kind, want.out_kind);
                    if (out_data.out_byte !== want.out_byte)
                        flag_mismatch("out_byte", out_data.out_byte, want.out_byte);
                    if (out_data.out_index !== want.out_index)
                        flag_mismatch("out_index", out_data.out_index, want.out_index);
                    if (out_data.status !== want.status)
                        flag_mismatch("status", int'(out_data.status), int'(want.status));
                    if (out_data.copied_count !== want.copied_count)
                        flag_mismatch("copied_count", out_data.copied_count,
                                      want.copied_count);
                    if (out_data.last !== want.last)
                        flag_mismatch("last", out_data.last, want.last);
                    if (want.last)
                        report_tally[want.status]++;
                    else
                        payload_checked++;
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic queue_byte(input logic [7:0] value);
        in_beat_t b;
        b.rx_byte = value;
        b.timed_out = 1'b0;
        rx_stream.push_back(b);
        beats_queued++;
    endtask

    // Timeout mark; the byte lane carries junk
    task automatic queue_timeout();
        in_beat_t b;
        b.rx_byte = 8'($urandom_range(0, 255));
        b.timed_out = 1'b1;
        rx_stream.push_back(b);
        beats_queued++;
    endtask

    function automatic logic [7:0] other_than(input logic [7:0] avoid);
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        while (v == avoid)
            v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    // Start, label, length, then (if len fits) random payload and end byte; cut_at aborts by timeout
    task automatic queue_frame(input logic [7:0] lbl, input int len,
                               input logic [7:0] end_byte, input int cut_at);
        queue_byte(START_CODE);
        queue_byte(lbl);
        queue_byte(len[7:0]);
        queue_byte(len[15:8]);
        if (len <= MAX_PAYLOAD_DEF)
        begin
            for (int i = 0; i < len; i++)
            begin
                if (i == cut_at)
                begin
                    queue_timeout();
                    return;
                end
                queue_byte(8'($urandom_range(0, 255)));
            end
            queue_byte(end_byte);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WANTED_LABEL)
            label_reg = value[BYTE_W-1:0];
        else
            limit_reg = value[IDX_W-1:0];
    endtask

    task automatic set_regs(input int lbl, input int limit);
        write_reg(CFG_WANTED_LABEL, lbl);
        write_reg(CFG_COPY_LIMIT, limit);
        settings_used++;
    endtask

    // Hold until every beat is taken and every result has come, then settle
    task automatic wait_drained();
        while (rx_stream.size() != 0 || beats_taken != beats_queued
               || frame_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed frames, with noise, timeouts and broken frames mixed in
    task automatic random_phase(input int quota);
        int base;
        int pick;
        int len;
        base = beats_queued;
        while (beats_queued - base < quota)
        begin
            pick = $urandom_range(0, 99);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            if (pick < 8)
                repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
            else if (pick < 14)
                queue_timeout();
            else if (pick < 22)
            begin
                queue_byte(START_CODE);
                queue_byte(other_than(label_reg));
            end
            else if (pick < 28)
                queue_frame(label_reg, $urandom_range(MAX_PAYLOAD_DEF + 1, 65535), END_CODE, -1);
            else if (pick < 34)
                queue_frame(label_reg, len, other_than(END_CODE), -1);
            else if (pick < 40)
                queue_frame(label_reg, len, END_CODE, $urandom_range(0, len));
            else
                queue_frame(label_reg, len, END_CODE, -1);
        end
        wait_drained();
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++)
            report_tally[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset registers (label 0, limit 600)
        queue_timeout();
        queue_frame(8'h00, 0, END_CODE, -1);
        queue_byte(START_CODE);
        queue_byte(8'h00);
        queue_byte(8'h02);
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(END_CODE);
        queue_frame(8'h00, MAX_PAYLOAD_DEF + 1, END_CODE, -1);
        queue_frame(8'h00, 1, 8'h00, -1);
        // Start code as a mismatched label is not rescanned; then time out mid-length
        queue_byte(START_CODE);
        queue_byte(START_CODE);
        queue_byte(START_CODE);
        queue_byte(8'h00);
        queue_byte(8'h01);
        queue_timeout();
        wait_drained();

        // Scan limit, retry limit, then a full-size frame under a long hold-off
        set_regs(8'hFF, MAX_PAYLOAD_DEF);
        repeat (SCAN_LIMIT_DEF) queue_byte(other_than(START_CODE));
        repeat (ATTEMPT_LIMIT_DEF)
        begin
            queue_byte(START_CODE);
            queue_byte(other_than(8'hFF));
        end
        wait_drained();
        hold_requests++;
        queue_frame(8'hFF, MAX_PAYLOAD_DEF, END_CODE, -1);
        wait_drained();

        // Random phases across register settings
        set_regs($urandom_range(0, 255), $urandom_range(1, 20));
        random_phase(110);
        set_regs(8'h00, 0);
        random_phase(110);
        set_regs(8'hFF, MAX_PAYLOAD_DEF);
        random_phase(110);
        set_regs($urandom_range(0, 255), 300);
        random_phase(110);
        calm = 1'b1;
        set_regs($urandom_range(0, 255), $urandom_range(0, MAX_PAYLOAD_DEF));
        random_phase(110);

        $display("Run covered %0d input beats under %0d register settings, scan and retry limits,",
                 beats_taken, settings_used);
        $display("%0d payload beats; reports ok/tmo/nostart/label/long/badend %0d/%0d/%0d/%0d/%0d/%0d",
                 payload_checked, report_tally[ST_OK], report_tally[ST_TIMEOUT],
                 report_tally[ST_NO_START], report_tally[ST_LABEL], report_tally[ST_TOO_LONG],
                 report_tally[ST_BAD_END]);
        if (mismatches == 0)
            $display("tb_widget_message_deframer: clean");
        else
            $display("tb_widget_message_deframer: errors");
        $finish;
    end

endmodule
